/* rtl/core/tspt_pkg.sv */
// Package for the tick/seconds periodic timer block.
// Holds register map, widths and reset values; no dependencies.
package tspt_pkg;

    localparam int MAX_TIMERS  = 4;
    localparam int DUR_IDX_W   = 2;
    localparam int DATA_W      = 32;
    localparam int PADDR_W     = 5;
    localparam int REG_IDX_W   = 3;

    // register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_CPTT  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CPTS  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_EN    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DUR0  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DUR3  = 3'd6;

    localparam logic [DATA_W-1:0] CPTT_RESET     = 32'd15000;
    localparam logic [DATA_W-1:0] CPTS_RESET     = 32'd15000000;
    localparam logic [DATA_W-1:0] DURATION_RESET = 32'd1000;

    localparam int NUM_TIMERS_DEFAULT = 4;

    // input operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ACK  = 1'b1;

endpackage

/* rtl/core/tspt_alu.sv */
// Shared 33-bit add/subtract unit with unsigned compare flag.
// Depends on tspt_pkg.
module tspt_alu (
    input  logic [tspt_pkg::DATA_W:0]   i_a,
    input  logic [tspt_pkg::DATA_W-1:0] i_b,
    input  logic                        i_sub,
    output logic [tspt_pkg::DATA_W:0]   o_res,
    output logic                        o_ge
);

    logic [tspt_pkg::DATA_W+1:0] w_b_ext;
    logic [tspt_pkg::DATA_W+1:0] w_sum;

    assign w_b_ext = i_sub ? ~{2'b00, i_b} : {2'b00, i_b};
    assign w_sum   = {1'b0, i_a} + w_b_ext + {{(tspt_pkg::DATA_W+1){1'b0}}, i_sub};
    assign o_res   = w_sum[tspt_pkg::DATA_W:0];
    // for a subtract, no borrow out means a >= b
    assign o_ge    = ~w_sum[tspt_pkg::DATA_W+1];

endmodule

/* rtl/core/tick_seconds_periodic_timers.sv */
// Top level of the tick/seconds periodic timer block: sequencer, state, APB registers.
// Depends on tspt_pkg and tspt_alu.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | to block  | i_in_valid / o_in_stall    | i_operation, i_ack_mask
//  out     | from block| o_out_valid / i_out_stall  | o_tick_count, o_seconds,
//          |           |                            | o_elapsed_mask, o_fired_mask
//  apb     | to block  | psel, penable, pready      | pwrite, paddr, pwdata, prdata
//
// A tick result goes through S_REM and S_SEC, then S_CMP per timer plus an S_ADV for
// each timer that fires, then S_DONE; the next transaction is taken once the sequencer
// is back in S_IDLE with no reload pending. An acknowledge goes straight to S_DONE.
// All of it runs through the one shared 33-bit adder: remainder add, seconds subtract,
// then a compare per timer and a deadline advance per timer that fires. A write to a
// duration or a newly set enable bit queues a deadline reload, done one timer a cycle
// while input stalls. Reset is synchronous and active low. The result sits in an
// output register, so a stalled output only blocks the next transaction from finishing,
// not starting.
module tick_seconds_periodic_timers #(
    parameter int NUM_TIMERS = tspt_pkg::NUM_TIMERS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_operation,
    input  logic [3:0]                    i_ack_mask,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [31:0]                   o_tick_count,
    output logic [31:0]                   o_seconds,
    output logic [3:0]                    o_elapsed_mask,
    output logic [3:0]                    o_fired_mask,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tspt_pkg::PADDR_W-1:0]  paddr,
    input  logic [tspt_pkg::DATA_W-1:0]   pwdata,
    output logic [tspt_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int TIDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [TIDX_W-1:0] LAST_IDX = TIDX_W'(NUM_TIMERS - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_REM  = 3'd1;  // remainder + cpu ticks per tick
    localparam logic [2:0] S_SEC  = 3'd2;  // sum - cpu ticks per second
    localparam logic [2:0] S_CMP  = 3'd3;  // tick count vs deadline
    localparam logic [2:0] S_ADV  = 3'd4;  // deadline += duration
    localparam logic [2:0] S_DONE = 3'd5;  // hand result to output register

    // config registers
    logic [31:0]           r_cptt, r_cpts;
    logic [NUM_TIMERS-1:0] r_en;
    logic [31:0]           r_dur [tspt_pkg::MAX_TIMERS];

    // timer state
    logic [31:0]           r_tick, r_sec, r_rem;
    logic [32:0]           r_sum;
    logic [31:0]           r_deadline [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] r_elapsed, r_fired, r_pend;
    logic [2:0]            r_state;
    logic [TIDX_W-1:0]     r_idx;

    // output register
    logic                  r_out_valid;
    logic [31:0]           r_o_tick, r_o_sec;
    logic [3:0]            r_o_elapsed, r_o_fired;

    // next values
    logic [31:0]           n_cptt, n_cpts, n_tick, n_sec, n_rem;
    logic [32:0]           n_sum;
    logic [NUM_TIMERS-1:0] n_en, n_elapsed, n_fired, n_pend;
    logic [31:0]           n_dur [tspt_pkg::MAX_TIMERS];
    logic [31:0]           n_deadline [NUM_TIMERS];
    logic [2:0]            n_state;
    logic [TIDX_W-1:0]     n_idx;
    logic                  n_out_valid;
    logic [31:0]           n_o_tick, n_o_sec;
    logic [3:0]            n_o_elapsed, n_o_fired;

    // shared unit
    logic [32:0]           w_alu_a;
    logic [31:0]           w_alu_b;
    logic                  w_alu_sub;
    logic [32:0]           w_alu_res;
    logic                  w_alu_ge;

    logic                  w_in_acc, w_out_acc, w_cfg_wr;
    logic [2:0]            w_reg_idx;
    logic [31:0]           w_dur_sel, w_dl_sel;
    logic [NUM_TIMERS-1:0] w_en_wr, w_idx_bit;
    logic [3:0]            w_elapsed_ext, w_fired_ext;

    assign pready     = 1'b1;
    assign w_reg_idx  = paddr[tspt_pkg::PADDR_W-1:2];
    assign w_cfg_wr   = psel & penable & pwrite & pready;
    assign o_in_stall = !((r_state == S_IDLE) && (r_pend == '0));
    assign w_in_acc   = i_in_valid & ~o_in_stall;
    assign w_out_acc  = r_out_valid & ~i_out_stall;

    assign w_dur_sel  = r_dur[tspt_pkg::DUR_IDX_W'(r_idx)];
    assign w_dl_sel   = r_deadline[r_idx];
    assign w_en_wr    = pwdata[NUM_TIMERS-1:0];

    always_comb begin
        w_idx_bit        = '0;
        w_idx_bit[r_idx] = 1'b1;
    end

    // operand select for the shared adder
    always_comb begin
        w_alu_a   = {1'b0, r_tick};
        w_alu_b   = w_dur_sel;
        w_alu_sub = 1'b0;
        case (r_state)
            S_REM: begin
                w_alu_a = {1'b0, r_rem};
                w_alu_b = r_cptt;
            end
            S_SEC: begin
                w_alu_a   = r_sum;
                w_alu_b   = r_cpts;
                w_alu_sub = 1'b1;
            end
            S_CMP: begin
                w_alu_b   = w_dl_sel;
                w_alu_sub = 1'b1;
            end
            S_ADV: begin
                w_alu_a = {1'b0, w_dl_sel};
            end
            default: begin
                // idle: deadline reload, tick count + duration
                w_alu_a = {1'b0, r_tick};
            end
        endcase
    end

    tspt_alu u_alu (
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .i_sub (w_alu_sub),
        .o_res (w_alu_res),
        .o_ge  (w_alu_ge)
    );

    // sequencer and timer state
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_tick     = r_tick;
        n_sec      = r_sec;
        n_rem      = r_rem;
        n_sum      = r_sum;
        n_elapsed  = r_elapsed;
        n_fired    = r_fired;
        n_pend     = r_pend;
        n_deadline = r_deadline;
        case (r_state)
            S_IDLE: begin
                if (r_pend != '0) begin
                    // reload sweep, one timer per cycle
                    if (r_pend[r_idx]) begin
                        n_deadline[r_idx] = w_alu_res[31:0];
                        n_pend            = r_pend & ~w_idx_bit;
                    end
                    n_idx = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
                end else if (w_in_acc) begin
                    n_idx   = '0;
                    n_fired = '0;
                    if (i_operation == tspt_pkg::OP_TICK) begin
                        n_tick  = r_tick + 32'd1;
                        n_state = S_REM;
                    end else begin
                        n_elapsed = r_elapsed & ~i_ack_mask[NUM_TIMERS-1:0];
                        n_state   = S_DONE;
                    end
                end
            end
            S_REM: begin
                n_sum   = w_alu_res;
                n_state = S_SEC;
            end
            S_SEC: begin
                if (w_alu_ge) begin
                    n_rem = w_alu_res[31:0];
                    n_sec = r_sec + 32'd1;
                end else begin
                    n_rem = r_sum[31:0];
                end
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_en[r_idx] && w_alu_ge) begin
                    n_elapsed = r_elapsed | w_idx_bit;
                    n_fired   = r_fired | w_idx_bit;
                    n_state   = S_ADV;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_ADV: begin
                n_deadline[r_idx] = w_alu_res[31:0];
                if (r_idx == LAST_IDX) begin
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_CMP;
                end
            end
            S_DONE: begin
                if (!r_out_valid || w_out_acc) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // register writes queue reloads; a new request wins over a sweep clear
        if (w_cfg_wr) begin
            if (w_reg_idx == tspt_pkg::REG_EN) begin
                n_pend = n_pend | (w_en_wr & ~r_en);
            end
            for (int k = 0; k < NUM_TIMERS; k++) begin
                if (w_reg_idx == tspt_pkg::REG_DUR0 + 3'(k)) begin
                    n_pend[k] = 1'b1;
                end
            end
        end
    end

    // config register writes
    always_comb begin
        n_cptt = r_cptt;
        n_cpts = r_cpts;
        n_en   = r_en;
        n_dur  = r_dur;
        if (w_cfg_wr) begin
            case (w_reg_idx)
                tspt_pkg::REG_CPTT: n_cptt = pwdata;
                tspt_pkg::REG_CPTS: n_cpts = pwdata;
                tspt_pkg::REG_EN:   n_en   = w_en_wr;
                default: begin
                    if (w_reg_idx inside {[tspt_pkg::REG_DUR0:tspt_pkg::REG_DUR3]}) begin
                        n_dur[tspt_pkg::DUR_IDX_W'(w_reg_idx - tspt_pkg::REG_DUR0)] = pwdata;
                    end
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (w_reg_idx)
            tspt_pkg::REG_CPTT: prdata = r_cptt;
            tspt_pkg::REG_CPTS: prdata = r_cpts;
            tspt_pkg::REG_EN:   prdata = 32'(r_en);
            default: begin
                if (w_reg_idx inside {[tspt_pkg::REG_DUR0:tspt_pkg::REG_DUR3]}) begin
                    prdata = r_dur[tspt_pkg::DUR_IDX_W'(w_reg_idx - tspt_pkg::REG_DUR0)];
                end else begin
                    prdata = '0;
                end
            end
        endcase
    end

    // output register
    always_comb begin
        w_elapsed_ext                   = '0;
        w_elapsed_ext[NUM_TIMERS-1:0]   = r_elapsed;
        w_fired_ext                     = '0;
        w_fired_ext[NUM_TIMERS-1:0]     = r_fired;
        n_out_valid = r_out_valid & ~w_out_acc;
        n_o_tick    = r_o_tick;
        n_o_sec     = r_o_sec;
        n_o_elapsed = r_o_elapsed;
        n_o_fired   = r_o_fired;
        if ((r_state == S_DONE) && (!r_out_valid || w_out_acc)) begin
            n_out_valid = 1'b1;
            n_o_tick    = r_tick;
            n_o_sec     = r_sec;
            n_o_elapsed = w_elapsed_ext;
            n_o_fired   = w_fired_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_tick      <= '0;
            r_sec       <= '0;
            r_rem       <= '0;
            r_elapsed   <= '0;
            r_fired     <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
            r_cptt      <= tspt_pkg::CPTT_RESET;
            r_cpts      <= tspt_pkg::CPTS_RESET;
            r_en        <= '0;
            for (int k = 0; k < tspt_pkg::MAX_TIMERS; k++) begin
                r_dur[k] <= tspt_pkg::DURATION_RESET;
            end
            for (int k = 0; k < NUM_TIMERS; k++) begin
                r_deadline[k] <= tspt_pkg::DURATION_RESET;
            end
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_tick      <= n_tick;
            r_sec       <= n_sec;
            r_rem       <= n_rem;
            r_elapsed   <= n_elapsed;
            r_fired     <= n_fired;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_cptt      <= n_cptt;
            r_cpts      <= n_cpts;
            r_en        <= n_en;
            r_dur       <= n_dur;
            r_deadline  <= n_deadline;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_sum       <= n_sum;
        r_o_tick    <= n_o_tick;
        r_o_sec     <= n_o_sec;
        r_o_elapsed <= n_o_elapsed;
        r_o_fired   <= n_o_fired;
    end

    assign o_out_valid    = r_out_valid;
    assign o_tick_count   = r_o_tick;
    assign o_seconds      = r_o_sec;
    assign o_elapsed_mask = r_o_elapsed;
    assign o_fired_mask   = r_o_fired;

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// Testbench for tick_seconds_periodic_timers: directed and random tick and acknowledge traffic
// with a self-contained timer predictor. Depends on tspt_pkg and the block RTL.
module tb;

    localparam int       CLK_HALF    = 6;         // 12 ns clock
    localparam int       N_TMR       = tspt_pkg::NUM_TIMERS_DEFAULT;
    localparam int       IDLE_PAUSE  = 16;        // covers a tick plus reloads
    localparam int       CYCLE_LIMIT = 600000;
    localparam logic [3:0] TIMER_BITS = 4'((1 << N_TMR) - 1);

    typedef logic [tspt_pkg::REG_IDX_W-1:0] t_reg_idx;

    // first index past the register map; writes there must be dropped
    localparam t_reg_idx REG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic [31:0] ticks;
        logic [31:0] secs;
        logic [3:0]  elapsed;
        logic [3:0]  fired;
    } t_timer_result;

    // ------------------------------------------------------------------
    // DUT signals; everything the testbench drives starts at a known value
    // ------------------------------------------------------------------
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    logic                i_operation = tspt_pkg::OP_TICK;
    logic [3:0]          i_ack_mask  = 4'h0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [31:0]         o_tick_count;
    logic [31:0]         o_seconds;
    logic [3:0]          o_elapsed_mask;
    logic [3:0]          o_fired_mask;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [tspt_pkg::PADDR_W-1:0] paddr  = '0;
    logic [tspt_pkg::DATA_W-1:0]  pwdata = '0;
    logic [tspt_pkg::DATA_W-1:0]  prdata;
    logic                pready;

    tick_seconds_periodic_timers #(
        .NUM_TIMERS (N_TMR)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_ack_mask     (i_ack_mask),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_tick_count   (o_tick_count),
        .o_seconds      (o_seconds),
        .o_elapsed_mask (o_elapsed_mask),
        .o_fired_mask   (o_fired_mask),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow copy of the block: registers and timer state
    // ------------------------------------------------------------------
    logic [31:0] cpu_per_tick;
    logic [31:0] cpu_per_sec;
    logic [3:0]  enable_bits;
    logic [31:0] period [4];
    logic [31:0] tick_cnt;
    logic [31:0] sec_cnt;
    logic [31:0] sec_rem;
    logic [31:0] deadline [4];
    logic [3:0]  elapsed;

    t_timer_result expected_results [$];

    int errors       = 0;
    int n_items      = 0;
    int n_results    = 0;
    int n_writes     = 0;
    int n_fired      = 0;
    int cycle_count  = 0;
    int tx_idle_pct  = 0;    // chance per cycle that the input side holds off
    int rx_idle_pct  = 0;    // chance per cycle that the output side stalls
    int hold_left    = 0;    // long output stall, counted down by the monitor

    function automatic void reset_shadow();
        cpu_per_tick = tspt_pkg::CPTT_RESET;
        cpu_per_sec  = tspt_pkg::CPTS_RESET;
        enable_bits  = 4'h0;
        tick_cnt     = '0;
        sec_cnt      = '0;
        sec_rem      = '0;
        elapsed      = 4'h0;
        for (int k = 0; k < 4; k++) begin
            period[k]   = tspt_pkg::DURATION_RESET;
            deadline[k] = tspt_pkg::DURATION_RESET;
        end
    endfunction

    // Register write side effects: period writes and rising enables reload deadlines.
    function automatic void shadow_write(input t_reg_idx idx, input logic [31:0] value);
        logic [3:0] new_en;
        logic [3:0] rising;
        int         k;
        case (idx)
            tspt_pkg::REG_CPTT: cpu_per_tick = value;
            tspt_pkg::REG_CPTS: cpu_per_sec  = value;
            tspt_pkg::REG_EN: begin
                new_en = value[3:0] & TIMER_BITS;
                rising = new_en & ~enable_bits;
                for (k = 0; k < N_TMR; k++)
                    if (rising[k]) deadline[k] = tick_cnt + period[k];
                enable_bits = new_en;
            end
            default: begin
                if (idx >= tspt_pkg::REG_DUR0 && idx <= tspt_pkg::REG_DUR3) begin
                    k = int'(idx - tspt_pkg::REG_DUR0);
                    period[k] = value;
                    if (k < N_TMR) deadline[k] = tick_cnt + value;
                end
            end
        endcase
    endfunction

    function automatic logic [31:0] reg_value(input t_reg_idx idx);
        case (idx)
            tspt_pkg::REG_CPTT: return cpu_per_tick;
            tspt_pkg::REG_CPTS: return cpu_per_sec;
            tspt_pkg::REG_EN:   return {28'h0, enable_bits};
            default:            return period[int'(idx - tspt_pkg::REG_DUR0)];
        endcase
    endfunction

    // One accepted transaction: advance the shadow and return the result it causes.
    function automatic t_timer_result predict_timer_step(input logic op, input logic [3:0] ack);
        t_timer_result r;
        logic [32:0]   sum;
        logic [3:0]    fired;
        fired = 4'h0;
        if (op == tspt_pkg::OP_TICK) begin
            tick_cnt = tick_cnt + 1;
            // 33-bit sum, reduced at most once, kept to 32 bits
            sum = {1'b0, sec_rem} + {1'b0, cpu_per_tick};
            if (sum >= {1'b0, cpu_per_sec}) begin
                sum     = sum - {1'b0, cpu_per_sec};
                sec_cnt = sec_cnt + 1;
            end
            sec_rem = sum[31:0];
            // plain unsigned compare; deadlines wrap
            for (int k = 0; k < N_TMR; k++) begin
                if (enable_bits[k] && tick_cnt >= deadline[k]) begin
                    deadline[k] = deadline[k] + period[k];
                    elapsed[k]  = 1'b1;
                    fired[k]    = 1'b1;
                end
            end
        end else begin
            elapsed = elapsed & ~ack;
        end
        elapsed   = elapsed & TIMER_BITS;
        r.ticks   = tick_cnt;
        r.secs    = sec_cnt;
        r.elapsed = elapsed;
        r.fired   = fired;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side: offer one transaction, with random hold-off first
    // ------------------------------------------------------------------
    task automatic send_item(input logic op, input logic [3:0] ack);
        t_timer_result want;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_ack_mask  <= ack;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        // accepted at this edge
        want = predict_timer_step(op, ack);
        expected_results.push_back(want);
        n_items++;
        n_fired += $countones(want.fired);
    endtask

    // Drop valid, let every outstanding result drain, then give the block time to settle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (IDLE_PAUSE) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // APB side
    // ------------------------------------------------------------------
    task automatic check_reg(input t_reg_idx idx);
        logic [31:0] want;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        want = reg_value(idx);
        if (prdata !== want) begin
            $error("register %0d readback: expected 0x%08h, actual 0x%08h", idx, want, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes only when idle; mapped registers are read back right after.
    task automatic reg_write(input t_reg_idx idx, input logic [31:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        shadow_write(idx, value);
        n_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx <= tspt_pkg::REG_DUR3) check_reg(idx);
    endtask

    // ------------------------------------------------------------------
    // Output side: check each accepted result, then pick the next stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_timer_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with nothing outstanding (tick_count %0d)",
                       o_tick_count);
                errors++;
            end else begin
                want = expected_results.pop_front();
                n_results++;
                if (o_tick_count !== want.ticks) begin
                    $error("tick_count: expected %0d, actual %0d", want.ticks, o_tick_count);
                    errors++;
                end
                if (o_seconds !== want.secs) begin
                    $error("seconds: expected %0d, actual %0d", want.secs, o_seconds);
                    errors++;
                end
                if (o_elapsed_mask !== want.elapsed) begin
                    $error("elapsed_mask: expected 0x%h, actual 0x%h",
                           want.elapsed, o_elapsed_mask);
                    errors++;
                end
                if (o_fired_mask !== want.fired) begin
                    $error("fired_mask: expected 0x%h, actual 0x%h", want.fired, o_fired_mask);
                    errors++;
                end
            end
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values readable; ticks with all timers disabled, ack on empty flags.
    task automatic test_reset_values();
        for (int i = 0; i <= int'(tspt_pkg::REG_DUR3); i++) check_reg(t_reg_idx'(i));
        repeat (3) send_item(tspt_pkg::OP_TICK, 4'($urandom_range(0, 15)));
        send_item(tspt_pkg::OP_ACK, 4'hF);
    endtask

    task automatic test_corner_cases();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // seconds roll every two or three ticks; periods 1, 2, zero and all-ones
        // (zero fires on every tick; all-ones wraps the deadline below the count)
        reg_write(tspt_pkg::REG_CPTT, 32'd5);
        reg_write(tspt_pkg::REG_CPTS, 32'd12);
        reg_write(tspt_pkg::REG_DUR0, 32'd1);
        reg_write(t_reg_idx'(tspt_pkg::REG_DUR0 + 1), 32'd2);
        reg_write(t_reg_idx'(tspt_pkg::REG_DUR0 + 2), 32'd0);
        reg_write(tspt_pkg::REG_DUR3, 32'hFFFF_FFFF);
        reg_write(tspt_pkg::REG_EN, 32'h0000_000F);
        repeat (5) send_item(tspt_pkg::OP_TICK, 4'($urandom_range(0, 15)));
        send_item(tspt_pkg::OP_ACK, 4'h0);
        send_item(tspt_pkg::OP_ACK, 4'h5);
        send_item(tspt_pkg::OP_ACK, 4'hF);
        // drop two enables and raise them again: only those reload
        reg_write(tspt_pkg::REG_EN, 32'h0000_0003);
        reg_write(tspt_pkg::REG_EN, 32'hFFFF_FFFF);
        reg_write(REG_UNMAPPED, 32'hDEAD_BEEF);
        repeat (3) send_item(tspt_pkg::OP_TICK, 4'($urandom_range(0, 15)));
        // per-tick above per-second: remainder sum needs the 33rd bit
        reg_write(tspt_pkg::REG_CPTT, 32'hFFFF_FFFF);
        reg_write(tspt_pkg::REG_CPTS, 32'd1);
        repeat (3) send_item(tspt_pkg::OP_TICK, 4'($urandom_range(0, 15)));
        reg_write(tspt_pkg::REG_CPTS, 32'hFFFF_FFFF);
        repeat (2) send_item(tspt_pkg::OP_TICK, 4'($urandom_range(0, 15)));
        reg_write(tspt_pkg::REG_CPTT, 32'd1);
        reg_write(tspt_pkg::REG_CPTS, 32'd1);
        send_item(tspt_pkg::OP_TICK, 4'($urandom_range(0, 15)));
    endtask

    // New random register setting; short periods dominate so timers fire often.
    task automatic randomize_config();
        logic [31:0] per_sec;
        case ($urandom_range(0, 3))
            0, 1: begin
                per_sec = $urandom_range(1, 40);
                reg_write(tspt_pkg::REG_CPTS, per_sec);
                reg_write(tspt_pkg::REG_CPTT, $urandom_range(1, per_sec));
            end
            2: begin
                reg_write(tspt_pkg::REG_CPTT, $urandom);
                reg_write(tspt_pkg::REG_CPTS, $urandom);
            end
            default: begin
                reg_write(tspt_pkg::REG_CPTT, $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1);
                reg_write(tspt_pkg::REG_CPTS, $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1);
            end
        endcase
        for (int k = 0; k < 4; k++) begin
            if ($urandom_range(0, 3) != 0)
                reg_write(t_reg_idx'(tspt_pkg::REG_DUR0 + k),
                          ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 10));
        end
        reg_write(tspt_pkg::REG_EN, $urandom_range(0, 15));
    endtask

    task automatic test_random_traffic(input int n, input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) randomize_config();
            send_item(($urandom_range(0, 99) < 25) ? tspt_pkg::OP_ACK : tspt_pkg::OP_TICK,
                      4'($urandom_range(0, 15)));
        end
    endtask

    // Output held off for a long stretch while input keeps coming: block must stall input.
    task automatic test_output_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_item(tspt_pkg::OP_TICK, 4'h0);
        hold_left = 300;
        repeat (40) send_item(($urandom_range(0, 99) < 25) ? tspt_pkg::OP_ACK
                                                           : tspt_pkg::OP_TICK,
                              4'($urandom_range(0, 15)));
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        reset_shadow();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_corner_cases();
        test_random_traffic(240, 19, 88);
        test_random_traffic(240, 88, 19);
        test_random_traffic(240, 0, 0);
        test_output_backpressure();
        wait_idle();

        $display("Ran %0d transactions (%0d results, %0d timer expirations), %0d register writes,",
                 n_items, n_results, n_fired, n_writes);
        $display("under input and output idling and one long output hold-off.");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
